// ===== design/dlfc_pkg.sv =====
// Shared types and constants for the display link frame checker.
`timescale 1ns / 1ps
package dlfc_pkg;

  localparam int FRAME_BYTES = 13;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int CK_POS      = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [7:0] SYNC_A   = 8'h32;
  localparam logic [7:0] SYNC_B   = 8'h37;
  localparam logic [7:0] SYNC_END = 8'h0E;

  localparam logic [7:0] DEFAULT_KEY_RST  = 8'd10;
  localparam logic [7:0] SEARCH_LIMIT_RST = 8'd50;
  localparam logic [2:0] PULL_MAX         = 3'd6;
  localparam logic [2:0] STEALTH_PULLS    = 3'd5;
  localparam logic [2:0] STEALTH_ASSIST   = 3'd6;
  localparam logic [5:0] SPEED_BASE       = 6'd10;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_KEY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT = 2'd1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CKSUM   = 2'd1,
    ST_TRAILER = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // completed frame, handed from the collector to the judge
  typedef struct packed {
    logic       done;
    logic       bad_trailer;
    logic       brake;
    logic [7:0] crc;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] b7;
  } frame_info_t;

  typedef struct packed {
    frame_status_t status;
    logic [2:0]    support_level;
    logic          light_on;
    logic [7:0]    motor_ratio;
    logic [4:0]    wheel_size_code;
    logic [5:0]    max_speed;
    logic          assist_mode_flag;
    logic [3:0]    max_current_code;
    logic [2:0]    pulse_code;
    logic [1:0]    assist_tuning;
    logic          stealth_active;
  } result_t;

  function automatic logic is_sync_head(input logic [7:0] b);
    is_sync_head = (b == SYNC_A) || (b == SYNC_B);
  endfunction

endpackage

// ===== design/dlfc_in_if.sv =====
// Input channel: received display bytes with the brake lever sample.
`timescale 1ns / 1ps
interface dlfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       brake_on;

  modport source (output valid, output rx_byte, output brake_on, input ready);
  modport sink   (input valid, input rx_byte, input brake_on, output ready);
endinterface

// ===== design/dlfc_out_if.sv =====
// Result channel: frame status and unpacked display settings.
`timescale 1ns / 1ps
interface dlfc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic [2:0] support_level;
  logic       light_on;
  logic [7:0] motor_ratio;
  logic [4:0] wheel_size_code;
  logic [5:0] max_speed;
  logic       assist_mode_flag;
  logic [3:0] max_current_code;
  logic [2:0] pulse_code;
  logic [1:0] assist_tuning;
  logic       stealth_active;

  modport source (output valid, output frame_status, output support_level, output light_on,
                  output motor_ratio, output wheel_size_code, output max_speed,
                  output assist_mode_flag, output max_current_code, output pulse_code,
                  output assist_tuning, output stealth_active, input ready);
  modport sink   (input valid, input frame_status, input support_level, input light_on,
                  input motor_ratio, input wheel_size_code, input max_speed,
                  input assist_mode_flag, input max_current_code, input pulse_code,
                  input assist_tuning, input stealth_active, output ready);
endinterface

// ===== design/dlfc_collect.sv =====
// Byte collector: frame store, running XOR, trailer check and resync hunt.
`timescale 1ns / 1ps
module dlfc_collect (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  input  logic                 brake_on,
  output dlfc_pkg::frame_info_t frame
);
  import dlfc_pkg::*;

  logic [7:0]       store_r [FRAME_BYTES];
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       xor_r, xor_nxt, xor_acc;
  logic             hunt_r, hunt_nxt;
  logic [7:0]       prev_r;
  logic             last;

  always_comb begin
    xor_acc = (idx_r == IDX_W'(CK_POS)) ? xor_r : (xor_r ^ rx_byte);
    last    = (idx_r >= IDX_W'(FRAME_BYTES - 1));

    frame             = '0;
    frame.brake       = brake_on;
    frame.crc         = xor_acc;
    frame.b1          = store_r[1];
    frame.b2          = store_r[2];
    frame.b3          = store_r[3];
    frame.b4          = store_r[4];
    frame.b5          = store_r[CK_POS];
    frame.b7          = store_r[7];
    frame.bad_trailer = !(is_sync_head(store_r[FRAME_BYTES-2]) && rx_byte == SYNC_END);

    idx_nxt  = idx_r;
    xor_nxt  = xor_r;
    hunt_nxt = hunt_r;
    if (accept) begin
      if (hunt_r) begin
        if (is_sync_head(prev_r) && rx_byte == SYNC_END) begin
          hunt_nxt = 1'b0;
          idx_nxt  = '0;
          xor_nxt  = '0;
        end
      end else if (last) begin
        frame.done = 1'b1;
        idx_nxt    = '0;
        xor_nxt    = '0;
        hunt_nxt   = frame.bad_trailer;
      end else begin
        idx_nxt = idx_r + 1'b1;
        xor_nxt = xor_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      xor_r  <= '0;
      hunt_r <= 1'b0;
      prev_r <= '0;
    end else begin
      idx_r  <= idx_nxt;
      xor_r  <= xor_nxt;
      hunt_r <= hunt_nxt;
      if (accept) prev_r <= rx_byte;
    end
  end

  // store has no reset; each entry that a frame reads is written earlier in that frame
  always_ff @(posedge clk) begin
    if (accept && !hunt_r && !last) store_r[idx_r] <= rx_byte;
  end

endmodule

// ===== design/dlfc_judge.sv =====
// Frame judge: key registers, checksum test, key learning, brake count, unpacking.
`timescale 1ns / 1ps
module dlfc_judge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dlfc_pkg::cfg_wr_t     cfg,
  input  dlfc_pkg::frame_info_t frame,
  output dlfc_pkg::result_t     result
);
  import dlfc_pkg::*;

  logic [7:0] dkey_r, limit_r;
  logic [7:0] lkey_r, lkey_nxt;
  logic [2:0] pulls_r, pulls_nxt;
  logic       stealth_r, stealth_nxt;
  logic       ck_ok;
  logic [7:0] diff;

  always_comb begin
    ck_ok = ((frame.crc ^ dkey_r) == frame.b5) || ((frame.crc ^ lkey_r) == frame.b5);
    diff  = frame.crc ^ frame.b5;

    lkey_nxt    = lkey_r;
    pulls_nxt   = pulls_r;
    stealth_nxt = stealth_r;

    result                = '0;
    result.stealth_active = stealth_r;

    if (frame.bad_trailer) begin
      result.status = ST_TRAILER;
    end else if (!ck_ok) begin
      result.status = ST_CKSUM;
      if (frame.done && diff <= limit_r) lkey_nxt = diff;
    end else begin
      result.status = ST_OK;
      if (pulls_r < PULL_MAX && (frame.brake ^ pulls_r[0])) pulls_nxt = pulls_r + 1'b1;
      if (frame.b1[2:0] == STEALTH_ASSIST && frame.brake && pulls_nxt == STEALTH_PULLS)
        stealth_nxt = 1'b1;
      result.support_level    = frame.b1[2:0];
      result.light_on         = frame.b1[7];
      result.motor_ratio      = frame.b3;
      result.wheel_size_code  = {frame.b2[2:0], frame.b4[7:6]};
      result.max_speed        = (SPEED_BASE + {1'b0, frame.b2[7:3]}) | {frame.b4[5], 5'b0};
      result.assist_mode_flag = frame.b4[3];
      result.max_current_code = frame.b7[3:0];
      result.pulse_code       = frame.b4[2:0];
      result.assist_tuning    = frame.b7[6:5];
      result.stealth_active   = stealth_nxt;
      if (!frame.done) begin
        pulls_nxt   = pulls_r;
        stealth_nxt = stealth_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dkey_r    <= DEFAULT_KEY_RST;
      limit_r   <= SEARCH_LIMIT_RST;
      lkey_r    <= '0;
      pulls_r   <= '0;
      stealth_r <= 1'b0;
    end else begin
      lkey_r    <= lkey_nxt;
      pulls_r   <= pulls_nxt;
      stealth_r <= stealth_nxt;
      if (cfg.we) begin
        case (cfg.index)
          CFG_DEFAULT_KEY:  dkey_r  <= cfg.data;
          CFG_SEARCH_LIMIT: limit_r <= cfg.data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== design/display_link_frame_checker_unit.sv =====
// Top level of the display link frame checker with its result register.
`timescale 1ns / 1ps
// Usage:
//   in_ch  carries one received display word per handshake (rx_byte, brake_on).
//          Words gather into 13-word frames; brake_on counts only on the last word.
//   out_ch carries one result word per completed frame: status plus settings.
//          Bad-trailer and checksum-fail results carry zeroed settings; stealth_active still shows the latch.
//   cfg_*  writes default_key (index 0) and key_search_limit (index 1), idle only.
// Timing:
//   One input word per cycle while in_ch.ready is high. The frame's last word
//   lands its result in the output register in the cycle after it is taken; the
//   combinational path is the running XOR, the key compare and the field unpack.
// Stall:
//   The output register holds until taken; in_ch.ready drops only while a
//   result waits and out_ch.ready is low, and returns in the cycle it is taken.
// Reset (rst_n, synchronous): keys return to 10 and 50, learned key, brake
//   count and stealth latch clear, the collector starts at byte 0, not hunting.
//   After a bad trailer no results come until a 0x32/0x37 then 0x0E pair is seen.
module display_link_frame_checker_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  dlfc_in_if.sink                          in_ch,
  dlfc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [dlfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dlfc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dlfc_pkg::*;

  logic        accept;
  frame_info_t frame;
  result_t     result;
  result_t     res_r;
  logic        out_valid_r;
  cfg_wr_t     cfg;

  // skid-free: a waiting result only blocks input while the sink stalls
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  dlfc_collect u_collect (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .rx_byte  (in_ch.rx_byte),
    .brake_on (in_ch.brake_on),
    .frame    (frame)
  );

  dlfc_judge u_judge (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .frame  (frame),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (frame.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (frame.done) res_r <= result;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.frame_status     = res_r.status;
  assign out_ch.support_level    = res_r.support_level;
  assign out_ch.light_on         = res_r.light_on;
  assign out_ch.motor_ratio      = res_r.motor_ratio;
  assign out_ch.wheel_size_code  = res_r.wheel_size_code;
  assign out_ch.max_speed        = res_r.max_speed;
  assign out_ch.assist_mode_flag = res_r.assist_mode_flag;
  assign out_ch.max_current_code = res_r.max_current_code;
  assign out_ch.pulse_code       = res_r.pulse_code;
  assign out_ch.assist_tuning    = res_r.assist_tuning;
  assign out_ch.stealth_active   = res_r.stealth_active;

  // a stalled result must block new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while result stalled");

  // a completed frame always lands in the output register
  a_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
    frame.done |=> out_valid_r)
    else $error("completed frame lost");

  // status code stays within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ch.frame_status != 2'd3))
    else $error("undefined frame status");

  // rejected frames carry no settings
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.status != ST_OK) |->
      (res_r.support_level == 3'd0) && (res_r.motor_ratio == 8'd0) &&
      (res_r.max_speed == 6'd0))
    else $error("settings leaked on rejected frame");

endmodule

// ===== tb/display_link_frame_checker_unit_tb.sv =====
// Self-checking bench for the display link frame checker: framed byte streams vs a predictor.
`timescale 1ns / 1ps
module display_link_frame_checker_unit_tb;
  import dlfc_pkg::*;

  // Stimulus frame flavors. SPAN_SYNC is a bad trailer whose last word is a
  // sync head, so the resync pair straddles the frame end and the first hunted word.
  typedef enum {
    FR_GOOD_DFLT,
    FR_GOOD_LEARN,
    FR_BAD_CKSUM,
    FR_BAD_TRAILER,
    FR_SPAN_SYNC
  } frame_kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       brake_on;
  } link_word_t;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register behind it
  localparam int HALF_SEG_WORDS = 76;                  // minimum words per half segment
  localparam int SEGMENTS       = 6;

  logic                  clk   = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dlfc_in_if  in_if ();
  dlfc_out_if out_if ();

  display_link_frame_checker_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the block's registers and frame tracker.
  // ---------------------------------------------------------------------------
  logic [7:0] key_dflt;
  logic [7:0] key_limit;
  logic [7:0] key_learned;
  logic [7:0] frame_buf [FRAME_BYTES];
  logic [3:0] word_pos;
  logic [7:0] xor_acc;
  logic [7:0] last_word;
  logic [2:0] pulls;
  logic       stealth;
  logic       hunt;

  result_t    frame_results_due [$];  // one entry per completed frame, oldest first
  link_word_t words_to_send [$];      // words waiting for the driver

  // Generator-side guesses, only used to shape stimulus (never for checking).
  logic [7:0] learned_guess;
  logic [2:0] pulls_guess;
  int         words_queued;

  int         in_idle_pct;
  int         out_idle_pct;
  int         mismatches;

  // Advance the frame tracker by one accepted word; a completed frame queues
  // its expected result word.
  task automatic track_frame_word(input logic [7:0] b, input logic brk);
    logic [7:0] prev;
    logic [7:0] crc;
    result_t    r;
    prev      = last_word;
    last_word = b;
    // while hunting only the sync pair matters; nothing is stored
    if (hunt) begin
      if ((prev == SYNC_A || prev == SYNC_B) && b == SYNC_END) begin
        hunt     = 1'b0;
        word_pos = '0;
        xor_acc  = '0;
      end
      return;
    end
    frame_buf[word_pos] = b;
    if (word_pos != CK_POS) xor_acc = xor_acc ^ b;
    word_pos = word_pos + 4'd1;
    if (word_pos < FRAME_BYTES) return;

    crc      = xor_acc;
    word_pos = '0;
    xor_acc  = '0;
    r        = '0;
    if (!((frame_buf[FRAME_BYTES-2] == SYNC_A || frame_buf[FRAME_BYTES-2] == SYNC_B) &&
          frame_buf[FRAME_BYTES-1] == SYNC_END)) begin
      // trailer broken: go hunting, settings stay zero
      hunt     = 1'b1;
      r.status = ST_TRAILER;
    end else if ((crc ^ key_dflt) != frame_buf[CK_POS] &&
                 (crc ^ key_learned) != frame_buf[CK_POS]) begin
      // neither key fits: the difference becomes the learned key if small enough
      if ((crc ^ frame_buf[CK_POS]) <= key_limit) key_learned = crc ^ frame_buf[CK_POS];
      r.status = ST_CKSUM;
    end else begin
      // brake pulls step on an alternating lever pattern, stop at the ceiling
      if (pulls < PULL_MAX && brk != pulls[0]) pulls = pulls + 3'd1;
      if (frame_buf[1][2:0] == STEALTH_ASSIST && brk && pulls == STEALTH_PULLS) stealth = 1'b1;
      r.status           = ST_OK;
      r.support_level    = frame_buf[1][2:0];
      r.light_on         = frame_buf[1][7];
      r.motor_ratio      = frame_buf[3];
      r.wheel_size_code  = {frame_buf[2][2:0], frame_buf[4][7:6]};
      r.max_speed        = SPEED_BASE + {1'b0, frame_buf[2][7:3]};
      r.max_speed[5]     = r.max_speed[5] | frame_buf[4][5];
      r.assist_mode_flag = frame_buf[4][3];
      r.max_current_code = frame_buf[7][3:0];
      r.pulse_code       = frame_buf[4][2:0];
      r.assist_tuning    = frame_buf[7][6:5];
    end
    r.stealth_active = stealth;
    frame_results_due.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents the oldest pending word, idles at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    link_word_t w;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) track_frame_word(in_if.rx_byte, in_if.brake_on);
      if (!in_if.valid || in_if.ready) begin
        if (words_to_send.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          w = words_to_send.pop_front();
          in_if.valid    <= 1'b1;
          in_if.rx_byte  <= w.rx_byte;
          in_if.brake_on <= w.brake_on;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: takes result words, compares against the oldest expectation,
  // and stalls the result side at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (frame_results_due.size() == 0) begin
          $error("result word with no completed frame behind it");
          mismatches++;
        end else begin
          want = frame_results_due.pop_front();
          check_field("frame_status", want.status, out_if.frame_status);
          check_field("support_level", want.support_level, out_if.support_level);
          check_field("light_on", want.light_on, out_if.light_on);
          check_field("motor_ratio", want.motor_ratio, out_if.motor_ratio);
          check_field("wheel_size_code", want.wheel_size_code, out_if.wheel_size_code);
          check_field("max_speed", want.max_speed, out_if.max_speed);
          check_field("assist_mode_flag", want.assist_mode_flag, out_if.assist_mode_flag);
          check_field("max_current_code", want.max_current_code, out_if.max_current_code);
          check_field("pulse_code", want.pulse_code, out_if.pulse_code);
          check_field("assist_tuning", want.assist_tuning, out_if.assist_tuning);
          check_field("stealth_active", want.stealth_active, out_if.stealth_active);
        end
      end
      out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [7:0] b, input logic brk);
    words_to_send.push_back('{rx_byte: b, brake_on: brk});
    words_queued++;
  endtask

  // Build one 13-word frame of the given flavor. brk lands on the last word,
  // the other brake samples are noise. After a bad trailer a resync pair follows.
  task automatic send_frame(input frame_kind_t kind, input logic brk,
                            input logic assist6, input logic all_ones);
    logic [7:0]  f [FRAME_BYTES];
    logic [7:0]  crc;
    logic [7:0]  d;
    int unsigned variant;
    int          i;
    crc = '0;
    for (i = 0; i < FRAME_BYTES; i++) f[i] = all_ones ? 8'hFF : 8'($urandom);
    if (assist6) f[1][2:0] = STEALTH_ASSIST;
    f[FRAME_BYTES-2] = $urandom_range(1) ? SYNC_A : SYNC_B;
    f[FRAME_BYTES-1] = SYNC_END;
    if (kind == FR_BAD_TRAILER || kind == FR_SPAN_SYNC) begin
      variant = (kind == FR_SPAN_SYNC) ? 2 : $urandom_range(2);
      case (variant)
        0:       f[FRAME_BYTES-2] = 8'($urandom);
        1:       f[FRAME_BYTES-1] = 8'($urandom);
        default: f[FRAME_BYTES-1] = f[FRAME_BYTES-2];  // sync head as last word
      endcase
      // random picks can land on a valid trailer; break it
      if ((f[FRAME_BYTES-2] == SYNC_A || f[FRAME_BYTES-2] == SYNC_B) &&
          f[FRAME_BYTES-1] == SYNC_END)
        f[FRAME_BYTES-1] = ~SYNC_END;
    end
    for (i = 0; i < FRAME_BYTES; i++) if (i != CK_POS) crc = crc ^ f[i];
    case (kind)
      FR_GOOD_DFLT:  f[CK_POS] = crc ^ key_dflt;
      FR_GOOD_LEARN: f[CK_POS] = crc ^ learned_guess;
      FR_BAD_CKSUM: begin
        // half the time a difference the block may learn
        d = $urandom_range(1) ? 8'($urandom_range(key_limit)) : 8'($urandom);
        f[CK_POS] = crc ^ d;
        if (d != key_dflt && d != learned_guess && d <= key_limit) learned_guess = d;
      end
      default: ;
    endcase
    for (i = 0; i < FRAME_BYTES; i++)
      push_word(f[i], (i == FRAME_BYTES - 1) ? brk : 1'($urandom));
    if (kind == FR_GOOD_DFLT && pulls_guess < PULL_MAX && brk != pulls_guess[0])
      pulls_guess = pulls_guess + 3'd1;
    if (kind == FR_BAD_TRAILER || kind == FR_SPAN_SYNC) begin
      if (f[FRAME_BYTES-1] != SYNC_A && f[FRAME_BYTES-1] != SYNC_B) begin
        repeat ($urandom_range(4)) push_word(8'($urandom), 1'($urandom));
        push_word($urandom_range(1) ? SYNC_A : SYNC_B, 1'($urandom));
      end
      push_word(SYNC_END, 1'($urandom));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DEFAULT_KEY) key_dflt = val;
    else if (idx == CFG_SEARCH_LIMIT) key_limit = val;
  endtask

  // Hold off until every queued word is in and every result word is out,
  // then let the block settle (hunted words make no result).
  task automatic wait_drained();
    do @(negedge clk);
    while (words_to_send.size() != 0 || in_if.valid || frame_results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          seg;
    int          half;
    int          start;
    int unsigned r;
    in_if.valid    = 1'b0;
    in_if.rx_byte  = '0;
    in_if.brake_on = 1'b0;
    out_if.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    key_dflt       = DEFAULT_KEY_RST;
    key_limit      = SEARCH_LIMIT_RST;
    key_learned    = '0;
    word_pos       = '0;
    xor_acc        = '0;
    last_word      = '0;
    pulls          = '0;
    stealth        = 1'b0;
    hunt           = 1'b0;
    learned_guess  = '0;
    pulls_guess    = '0;
    words_queued   = 0;
    mismatches     = 0;
    in_idle_pct    = 14;
    out_idle_pct   = 68;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: an all-ones good frame (field maxima), then a bad trailer
    // whose sync pair spans into the hunt.
    send_frame(FR_GOOD_DFLT, 1'b1, 1'b0, 1'b1);
    send_frame(FR_SPAN_SYNC, 1'b0, 1'b0, 1'b0);

    // Random part opens with the lever pattern that walks the pull count up to
    // its ceiling, assist 6 on every frame, so stealth engages on the way.
    while (pulls_guess < PULL_MAX) send_frame(FR_GOOD_DFLT, ~pulls_guess[0], 1'b1, 1'b0);

    for (seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      case (seg)
        1: begin
          write_reg(CFG_DEFAULT_KEY, 8'h00);
          write_reg(CFG_SEARCH_LIMIT, 8'hFF);
        end
        2: begin
          write_reg(CFG_DEFAULT_KEY, 8'hFF);
          write_reg(CFG_SEARCH_LIMIT, 8'h00);
        end
        3: begin
          write_reg(CFG_UNUSED, 8'($urandom));  // must be ignored
          write_reg(CFG_DEFAULT_KEY, 8'($urandom));
          write_reg(CFG_SEARCH_LIMIT, 8'($urandom));
        end
        4: begin
          write_reg(CFG_DEFAULT_KEY, 8'($urandom));
          write_reg(CFG_SEARCH_LIMIT, 8'($urandom_range(255, 200)));
        end
        5: begin
          write_reg(CFG_DEFAULT_KEY, DEFAULT_KEY_RST);
          write_reg(CFG_SEARCH_LIMIT, 8'($urandom_range(20)));
        end
        default: ;
      endcase
      // sender-light / receiver-heavy, then swapped, then full rate
      in_idle_pct  = (seg < 2) ? 14 : (seg < 4) ? 68 : 0;
      out_idle_pct = (seg < 2) ? 68 : (seg < 4) ? 14 : 0;
      for (half = 0; half < 2; half++) begin
        // mid-segment the sender holds until every result word is back
        if (half != 0) wait_drained();
        start = words_queued;
        while (words_queued - start < HALF_SEG_WORDS) begin
          r = $urandom_range(99);
          if (r < 50)      send_frame(FR_GOOD_DFLT, 1'($urandom), $urandom_range(7) == 0, 1'b0);
          else if (r < 65) send_frame(FR_GOOD_LEARN, 1'($urandom), $urandom_range(7) == 0, 1'b0);
          else if (r < 82) send_frame(FR_BAD_CKSUM, 1'($urandom), 1'b0, 1'b0);
          else if (r < 90) send_frame(FR_BAD_TRAILER, 1'($urandom), 1'b0, 1'b0);
          else if (r < 93) send_frame(FR_SPAN_SYNC, 1'($urandom), 1'b0, 1'b0);
          else begin
            // stray words knock the collector out of step
            repeat ($urandom_range(3, 1)) push_word(8'($urandom), 1'($urandom));
          end
        end
      end
    end

    wait_drained();
    if (mismatches == 0 && frame_results_due.size() == 0) begin
      $display("display_link_frame_checker_unit_tb: PASS");
    end else begin
      $display("display_link_frame_checker_unit_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("display_link_frame_checker_unit_tb: FAIL");
    $finish;
  end

endmodule
